>>> rtl/lsfg_pkg.sv
// Package for the load-step frequency governor.
// Holds field widths, register indexes, reset values and arithmetic constants.
// No dependencies.
package lsfg_pkg;

	localparam int FREQ_BITS_DEF = 24;
	localparam int PCT_W         = 7;
	localparam int TALLY_W       = 8;
	localparam int CFG_IDX_W     = 3;

	// Divisor of the step computation and the step used when it comes out zero.
	localparam int PERCENT_SCALE = 100;
	localparam int STEP_FALLBACK = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_UP_THRESHOLD  = 3'd0,
		REG_LOW_THRESHOLD = 3'd1,
		REG_SECOND_LOW    = 3'd2,
		REG_STEP_PERCENT  = 3'd3,
		REG_BOOST_ON      = 3'd4,
		REG_BOOST_THRESH  = 3'd5,
		REG_MIN_FREQ      = 3'd6,
		REG_MAX_FREQ      = 3'd7
	} cfg_reg_t;

	localparam logic [PCT_W-1:0]   UP_THRESHOLD_RST = 7'd85;
	localparam logic [PCT_W-1:0]   LOW_THRESHOLD_RST = 7'd35;
	localparam logic [PCT_W-1:0]   SECOND_LOW_RST = 7'd45;
	localparam logic [PCT_W-1:0]   STEP_PERCENT_RST = 7'd5;
	localparam logic               BOOST_ON_RST = 1'b1;
	localparam logic [TALLY_W-1:0] BOOST_THRESH_RST = 8'd8;
	localparam logic [31:0]        MIN_FREQ_RST = 32'd300000;
	localparam logic [31:0]        MAX_FREQ_RST = 32'd2000000;

	localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_NOTICE = 1'b1
	} op_t;

	typedef enum logic {
		ROUND_UP   = 1'b0,
		ROUND_DOWN = 1'b1
	} rounding_t;

endpackage

>>> rtl/lsfg_step_div.sv
// Division of the step numerator by the percent scale through a reciprocal multiply.
// Three registered stages: shifted numerator, partial products, quotient.
// Depends on lsfg_pkg.
module lsfg_step_div
	import lsfg_pkg::*;
#(
	parameter int NUM_W = FREQ_BITS_DEF + PCT_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	output logic             busy,
	output logic [NUM_W-1:0] quot
);

	// Dividing by four first leaves an odd factor of 25. Its rounded-up reciprocal
	// is exact for every dividend of XW bits, since the rounding error times 2^XW
	// stays below 2^K.
	localparam int PRE_SHIFT = 2;
	localparam int ODD_DIV   = PERCENT_SCALE >> PRE_SHIFT;
	localparam int XW        = NUM_W - PRE_SHIFT;
	localparam int K         = XW + 5;
	localparam int RECIP_W   = XW + 1;
	localparam int LO_W      = 16;
	localparam int HI_W      = XW - LO_W;
	localparam int PROD_W    = XW + RECIP_W;
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << K) + 64'(ODD_DIV) - 64'd1) / 64'(ODD_DIV);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

	logic                    v_s1;
	logic                    v_s2;
	logic [XW-1:0]           x_s1;
	logic [LO_W+RECIP_W-1:0] lo_prod_s2;
	logic [HI_W+RECIP_W-1:0] hi_prod_s2;
	logic [PROD_W-1:0]       prod;
	logic [NUM_W-1:0]        quot_q;

	assign prod = {hi_prod_s2, LO_W'(0)} + PROD_W'(lo_prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
		end
	end

	// The multiply is split in two parts of the dividend to keep each product narrow.
	always_ff @(posedge clk) begin
		if (start) begin
			x_s1 <= numer[NUM_W-1:PRE_SHIFT];
		end
		if (v_s1) begin
			lo_prod_s2 <= (LO_W+RECIP_W)'(x_s1[LO_W-1:0]) * (LO_W+RECIP_W)'(RECIP);
			hi_prod_s2 <= (HI_W+RECIP_W)'(x_s1[XW-1:LO_W]) * (HI_W+RECIP_W)'(RECIP);
		end
		if (v_s2) begin
			quot_q <= NUM_W'(prod[PROD_W-1:K]);
		end
	end

	assign busy = v_s1 || v_s2;
	assign quot = quot_q;

	assert property (@(posedge clk) disable iff (!arst_n) start |=> busy)
		else $error("step divider did not start");
	assert property (@(posedge clk) disable iff (!arst_n) v_s1 |=> v_s2)
		else $error("step divider skipped its product stage");
	assert property (@(posedge clk) disable iff (!arst_n)
		(!start && !busy) |=> $stable(quot_q))
		else $error("step quotient changed while idle");

endmodule

>>> rtl/load_step_frequency_governor_top.sv
// Top level of the load-step frequency governor.
// Holds the configuration registers, the governor state and the datapath.
// Depends on lsfg_pkg and lsfg_step_div.
//
//  channel | signals                                          | beat moves
//  --------+--------------------------------------------------+------------------------
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data        | one register write
//  in      | in_valid, in_ready, op, load, cur_freq, new_freq | one sample or notice
//  out     | out_valid, out_ready, target_freq, rounding      | one frequency request
//
// An input beat lands in an input register and then updates the state and the result
// register, one beat per cycle while the output and the step divider do not stall.
// After reset and after every configuration write the step is recomputed through the
// stages numerator, partial products and quotient, and in_ready stays low meanwhile.
// A stalled result register holds the input register, which then holds in_ready low.
// cfg_ready is always high.
module load_step_frequency_governor_top
	import lsfg_pkg::*;
#(
	parameter int FREQ_BITS = FREQ_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FREQ_BITS-1:0] cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 op,
	input  logic [PCT_W-1:0]     load,
	input  logic [FREQ_BITS-1:0] cur_freq,
	input  logic [FREQ_BITS-1:0] new_freq,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [FREQ_BITS-1:0] target_freq,
	output logic                 rounding
);

	localparam int NUM_W  = FREQ_BITS + PCT_W;
	localparam int STEP_W = FREQ_BITS + 1;

	// Configuration registers.
	logic [PCT_W-1:0]     up_threshold_q;
	logic [PCT_W-1:0]     low_threshold_q;
	logic [PCT_W-1:0]     second_low_q;
	logic [PCT_W-1:0]     step_percent_q;
	logic                 boost_on_q;
	logic [TALLY_W-1:0]   boost_thresh_q;
	logic [FREQ_BITS-1:0] min_freq_q;
	logic [FREQ_BITS-1:0] max_freq_q;

	// Governor state.
	logic [FREQ_BITS-1:0] request_freq_q;
	logic [TALLY_W-1:0]   boost_tally_q;

	// Input register.
	logic                 valid_s1;
	logic                 op_s1;
	logic [PCT_W-1:0]     load_s1;
	logic [FREQ_BITS-1:0] cur_freq_s1;
	logic [FREQ_BITS-1:0] new_freq_s1;

	// Result register.
	logic                 out_valid_q;
	logic [FREQ_BITS-1:0] target_freq_q;
	logic                 rounding_q;

	logic                 start_q;
	logic                 div_run;
	logic                 div_busy;
	logic [NUM_W-1:0]     div_numer;
	logic [NUM_W-1:0]     div_quot;
	logic [STEP_W-1:0]    step;

	logic                 cfg_fire;
	logic                 out_free;
	logic                 advance;

	logic [FREQ_BITS-1:0] req_next;
	logic [TALLY_W-1:0]   tally_next;
	logic                 emit;
	logic                 round_next;
	logic [FREQ_BITS-1:0] down_freq;
	logic                 down_clears;
	logic [FREQ_BITS+1:0] up_sum;
	logic [FREQ_BITS-1:0] up_freq;
	logic [TALLY_W-1:0]   tally_dec;
	logic [TALLY_W-1:0]   tally_inc;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_threshold_q  <= UP_THRESHOLD_RST;
			low_threshold_q <= LOW_THRESHOLD_RST;
			second_low_q    <= SECOND_LOW_RST;
			step_percent_q  <= STEP_PERCENT_RST;
			boost_on_q      <= BOOST_ON_RST;
			boost_thresh_q  <= BOOST_THRESH_RST;
			min_freq_q      <= MIN_FREQ_RST[FREQ_BITS-1:0];
			max_freq_q      <= MAX_FREQ_RST[FREQ_BITS-1:0];
		end else if (cfg_fire) begin
			case (cfg_reg_t'(cfg_index))
				REG_UP_THRESHOLD:  up_threshold_q  <= cfg_data[PCT_W-1:0];
				REG_LOW_THRESHOLD: low_threshold_q <= cfg_data[PCT_W-1:0];
				REG_SECOND_LOW:    second_low_q    <= cfg_data[PCT_W-1:0];
				REG_STEP_PERCENT:  step_percent_q  <= cfg_data[PCT_W-1:0];
				REG_BOOST_ON:      boost_on_q      <= cfg_data[0];
				REG_BOOST_THRESH:  boost_thresh_q  <= cfg_data[TALLY_W-1:0];
				REG_MIN_FREQ:      min_freq_q      <= cfg_data;
				REG_MAX_FREQ:      max_freq_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// The step recomputation from the registers starts out of reset and in the cycle after any write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
		end else begin
			start_q <= cfg_fire;
		end
	end

	assign div_numer = NUM_W'(step_percent_q) * NUM_W'(max_freq_q);

	lsfg_step_div #(
		.NUM_W (NUM_W)
	) u_step_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.numer  (div_numer),
		.busy   (div_run),
		.quot   (div_quot)
	);

	assign div_busy = start_q || div_run;
	assign step     = (div_quot == '0) ? STEP_W'(STEP_FALLBACK) : div_quot[STEP_W-1:0];

	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !div_busy && (!valid_s1 || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1       <= op;
			load_s1     <= load;
			cur_freq_s1 <= cur_freq;
			new_freq_s1 <= new_freq;
		end
	end

	// Step-down and step-up candidates.
	assign down_clears = !({1'b0, request_freq_q} > step);
	assign down_freq   = down_clears ? min_freq_q
		: FREQ_BITS'({1'b0, request_freq_q} - step);
	assign up_sum      = {2'b00, request_freq_q} + {1'b0, step};
	assign up_freq     = (up_sum[FREQ_BITS+1:FREQ_BITS] != 2'b00) ? '1
		: up_sum[FREQ_BITS-1:0];
	assign tally_dec   = (boost_tally_q != '0) ? boost_tally_q - 1'b1 : boost_tally_q;
	assign tally_inc   = (boost_tally_q != TALLY_MAX) ? boost_tally_q + 1'b1 : boost_tally_q;

	always_comb begin
		req_next   = request_freq_q;
		tally_next = boost_tally_q;
		emit       = 1'b0;
		round_next = ROUND_UP;
		if (op_s1 == OP_NOTICE) begin
			if (request_freq_q > max_freq_q || request_freq_q < min_freq_q) begin
				req_next = new_freq_s1;
			end
		end else if (cur_freq_s1 != min_freq_q && step_percent_q != '0) begin
			if (load_s1 < low_threshold_q) begin
				req_next   = down_freq;
				tally_next = down_clears ? '0 : tally_dec;
				emit       = 1'b1;
			end else if (load_s1 <= second_low_q) begin
				req_next   = down_freq;
				tally_next = down_clears ? '0 : boost_tally_q;
				emit       = 1'b1;
			end else if (load_s1 > up_threshold_q && request_freq_q != max_freq_q) begin
				if (boost_on_q && boost_tally_q >= boost_thresh_q) begin
					req_next   = max_freq_q;
					tally_next = '0;
				end else begin
					req_next   = up_freq;
					tally_next = tally_inc;
				end
				emit       = 1'b1;
				round_next = ROUND_DOWN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			request_freq_q <= '0;
			boost_tally_q  <= '0;
		end else if (advance) begin
			request_freq_q <= req_next;
			boost_tally_q  <= tally_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			target_freq_q <= req_next;
			rounding_q    <= round_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign target_freq = target_freq_q;
	assign rounding    = rounding_q;

	assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && div_busy))
		else $error("input taken while the step is being recomputed");
	assert property (@(posedge clk) disable iff (!arst_n) cfg_fire |=> !in_ready)
		else $error("input not held off after a configuration write");
	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(request_freq_q) && $stable(boost_tally_q)))
		else $error("governor state changed without an item");
	assert property (@(posedge clk) disable iff (!arst_n) !div_busy |-> (step != '0))
		else $error("step size is zero");

endmodule
